FILE: rtl/dlsc_pkg.sv
// shared types, constants and decode for the debounced load switch controller
package dlsc_pkg;

    localparam int CNT_W   = 16;
    localparam int OP_W    = 2;
    localparam int CIDX_W  = 2;
    localparam int DRIVE_W = 5;

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_EDGE = 2'd1;
    localparam logic [OP_W-1:0] OP_BYTE = 2'd2;
    localparam logic [OP_W-1:0] OP_WAKE = 2'd3;

    localparam logic [CIDX_W-1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_PANIC     = 2'd1;
    localparam logic [CIDX_W-1:0] REG_KEEPALIVE = 2'd2;
    localparam logic [CIDX_W-1:0] REG_WAKEUP    = 2'd3;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET  = 16'd200;
    localparam logic [CNT_W-1:0] PANIC_RESET     = 16'd1000;
    localparam logic [CNT_W-1:0] KEEPALIVE_RESET = 16'd1000;
    localparam logic [CNT_W-1:0] WAKEUP_RESET    = 16'd100;
    localparam logic [CNT_W-1:0] STARTUP_TICKS   = 16'd500;

    // drive bit positions
    localparam int DRV_PRIMARY = 0;
    localparam int DRV_SECOND  = 1;
    localparam int DRV_THIRD   = 2;
    localparam int DRV_AWAY    = 3;
    localparam int DRV_HOME    = 4;

    // result word bit positions
    localparam int RES_HEARTBEAT = 5;
    localparam int RES_RUNNING   = 6;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] panic_ticks;
        logic [CNT_W-1:0] keepalive_ticks;
        logic [CNT_W-1:0] wakeup_ticks;
    } dlsc_cfg_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            away_switch_n;
        logic            home_switch_n;
        logic            battery_good;
    } dlsc_item_t;

    typedef struct packed {
        logic               running;
        logic               heartbeat_led;
        logic [DRIVE_W-1:0] drive;
    } dlsc_res_t;

    function automatic logic [DRIVE_W-1:0] settle_drive(input logic away_n,
                                                        input logic home_n,
                                                        input logic batt_ok);
        logic [DRIVE_W-1:0] d;
        d = '0;
        if (batt_ok && !home_n) begin
            d[DRV_PRIMARY] = 1'b1;
            d[DRV_SECOND]  = 1'b1;
            d[DRV_THIRD]   = 1'b1;
            d[DRV_HOME]    = 1'b1;
        end else if (batt_ok && !away_n) begin
            d[DRV_PRIMARY] = 1'b1;
            d[DRV_AWAY]    = 1'b1;
        end
        return d;
    endfunction

endpackage

FILE: rtl/dlsc_cfg.sv
// configuration register file: debounce, panic and keep-awake loads
module dlsc_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [dlsc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [dlsc_pkg::CNT_W-1:0]    cfg_wdata,
    output dlsc_pkg::dlsc_cfg_t           cfg
);
    import dlsc_pkg::*;

    dlsc_cfg_t cfg_reg;
    dlsc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_DEBOUNCE:  cfg_next.debounce_ticks  = cfg_wdata;
                REG_PANIC:     cfg_next.panic_ticks     = cfg_wdata;
                REG_KEEPALIVE: cfg_next.keepalive_ticks = cfg_wdata;
                REG_WAKEUP:    cfg_next.wakeup_ticks    = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks  <= DEBOUNCE_RESET;
            cfg_reg.panic_ticks     <= PANIC_RESET;
            cfg_reg.keepalive_ticks <= KEEPALIVE_RESET;
            cfg_reg.wakeup_ticks    <= WAKEUP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/dlsc_core.sv
// countdown state and per-word update: debounce, panic, keep-awake, drive bits
module dlsc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  dlsc_pkg::dlsc_item_t item,
    input  dlsc_pkg::dlsc_cfg_t  cfg,
    output dlsc_pkg::dlsc_res_t  res
);
    import dlsc_pkg::*;

    logic [CNT_W-1:0]   debounce_cnt_reg, debounce_cnt_next;
    logic [CNT_W-1:0]   panic_cnt_reg, panic_cnt_next;
    logic [CNT_W-1:0]   awake_cnt_reg, awake_cnt_next;
    logic [DRIVE_W-1:0] drive_reg, drive_next;
    logic               heartbeat_reg, heartbeat_next;
    logic               running_reg, running_next;

    logic [CNT_W-1:0] debounce_dec;
    logic [CNT_W-1:0] panic_dec;
    logic [CNT_W-1:0] awake_dec;
    logic             run;

    assign debounce_dec = debounce_cnt_reg - 1'b1;
    assign panic_dec    = panic_cnt_reg - 1'b1;
    assign awake_dec    = awake_cnt_reg - 1'b1;

    always_comb begin
        debounce_cnt_next = debounce_cnt_reg;
        panic_cnt_next    = panic_cnt_reg;
        awake_cnt_next    = awake_cnt_reg;
        drive_next        = drive_reg;
        heartbeat_next    = heartbeat_reg;
        running_next      = running_reg;
        run               = 1'b0;
        case (item.op)
            OP_TICK: begin
                heartbeat_next = !heartbeat_reg;
                if (debounce_cnt_reg != '0) begin
                    debounce_cnt_next = debounce_dec;
                    if (debounce_dec != '0) begin
                        // still bouncing: panic countdown runs
                        run = 1'b1;
                        if (panic_cnt_reg != '0) begin
                            panic_cnt_next = panic_dec;
                            if (panic_dec == '0) begin
                                drive_next = '0;
                            end
                        end
                    end else begin
                        panic_cnt_next = cfg.panic_ticks;
                        drive_next     = settle_drive(item.away_switch_n,
                                                      item.home_switch_n,
                                                      item.battery_good);
                    end
                end
                if (awake_cnt_reg != '0) begin
                    awake_cnt_next = awake_dec;
                    if (awake_dec != '0) begin
                        run = 1'b1;
                    end
                end
                running_next = run;
            end
            OP_EDGE: begin
                debounce_cnt_next = cfg.debounce_ticks;
            end
            OP_BYTE: begin
                awake_cnt_next = cfg.keepalive_ticks;
            end
            OP_WAKE: begin
                awake_cnt_next = cfg.wakeup_ticks;
                running_next   = 1'b1;
            end
            default: begin
                running_next = running_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_cnt_reg <= STARTUP_TICKS;
            panic_cnt_reg    <= PANIC_RESET;
            awake_cnt_reg    <= '0;
            drive_reg        <= '0;
            heartbeat_reg    <= 1'b0;
            running_reg      <= 1'b1;
        end else if (step) begin
            debounce_cnt_reg <= debounce_cnt_next;
            panic_cnt_reg    <= panic_cnt_next;
            awake_cnt_reg    <= awake_cnt_next;
            drive_reg        <= drive_next;
            heartbeat_reg    <= heartbeat_next;
            running_reg      <= running_next;
        end
    end

    assign res.drive         = drive_next;
    assign res.heartbeat_led = heartbeat_next;
    assign res.running       = running_next;

endmodule

FILE: rtl/debounced_load_switch_controller.sv
// top level: stream ports, input register, result register and checks
// Takes one event word per cycle (tick, input edge, serial byte, wake from
// halt) while the output is not stalled, and returns exactly one status word
// per event. A word passes through an input register and a result register,
// whose valid is m_tvalid; a stalled output holds it in the input register.
// The state update between the two is combinational, which sets the
// sustained rate of one word per clock. Configuration writes on cfg_we take
// effect on the next clock and should be made only while no word is in flight.
// After reset the drive bits are off and the debounce countdown is armed with the startup tick count.
module debounced_load_switch_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // away_switch_n, home_switch_n, battery_good, zero pad
    input  logic [dlsc_pkg::OP_W-1:0]     s_tuser,   // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // group_primary, group_second, group_third,
                                                     // away_led, home_led, heartbeat_led, running, zero pad
    input  logic                          cfg_we,
    input  logic [dlsc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [dlsc_pkg::CNT_W-1:0]    cfg_wdata
);
    import dlsc_pkg::*;

    dlsc_cfg_t  cfg;
    dlsc_item_t in_reg;
    logic       in_valid_reg;
    dlsc_res_t  res;
    dlsc_res_t  out_reg;
    logic       out_valid_reg;
    logic       advance;

    // the stage moves when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.op            <= s_tuser;
            in_reg.away_switch_n <= s_tdata[0];
            in_reg.home_switch_n <= s_tdata[1];
            in_reg.battery_good  <= s_tdata[2];
        end
    end

    dlsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dlsc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.running, out_reg.heartbeat_led, out_reg.drive};

    // a stalled input side means both registers are holding words
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled without a full pipeline");

    // wake from halt always reports running
    a_wake_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.op == OP_WAKE) |=> (m_tvalid && m_tdata[RES_RUNNING]))
        else $error("wake word did not report running");

    // home and away indicators are never lit together
    a_led_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[DRV_AWAY] && m_tdata[DRV_HOME]))
        else $error("home and away indicators both lit");

    // only a tick can move the heartbeat
    a_hb_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.op != OP_TICK && $past(advance) && $past(aresetn))
        |=> (out_reg.heartbeat_led == $past(out_reg.heartbeat_led)))
        else $error("heartbeat moved on a non-tick word");

endmodule

FILE: tb/dlsc_checker.sv
// watches both streams, predicts each status word and compares it on arrival
module dlsc_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic [dlsc_pkg::OP_W-1:0]   s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [7:0]                  m_tdata,
    input  logic                        cfg_we,
    input  logic [dlsc_pkg::CIDX_W-1:0] cfg_index,
    input  logic [dlsc_pkg::CNT_W-1:0]  cfg_wdata,
    output int                          pending,
    output int                          fails
);
    import dlsc_pkg::*;

    // settings as last written
    logic [CNT_W-1:0] quiet_ticks;
    logic [CNT_W-1:0] bounce_limit;
    logic [CNT_W-1:0] serial_load;
    logic [CNT_W-1:0] wake_load;

    // predicted controller state
    logic [CNT_W-1:0]   quiet_left;
    logic [CNT_W-1:0]   bounce_left;
    logic [CNT_W-1:0]   awake_left;
    logic [DRIVE_W-1:0] loads;
    logic               beat;
    logic               busy;

    dlsc_res_t status_q[$];
    int        word_no;

    string field_name [7] = '{"group_primary", "group_second", "group_third", "away_led",
                              "home_led", "heartbeat_led", "running"};

    initial begin
        pending = 0;
        fails   = 0;
        word_no = 0;
    end

    // pins: bit 0 away_switch_n, bit 1 home_switch_n, bit 2 battery_good
    function automatic logic [DRIVE_W-1:0] pick_loads(input logic [2:0] pins);
        logic [DRIVE_W-1:0] d;
        d = '0;
        if (pins[2] && !pins[1]) begin
            d = DRIVE_W'((1 << DRV_PRIMARY) | (1 << DRV_SECOND) | (1 << DRV_THIRD)
                         | (1 << DRV_HOME));
        end else if (pins[2] && !pins[0]) begin
            d = DRIVE_W'((1 << DRV_PRIMARY) | (1 << DRV_AWAY));
        end
        return d;
    endfunction

    task automatic step_status(input logic [OP_W-1:0] op, input logic [2:0] pins,
                               output dlsc_res_t r);
        logic active;
        active = 1'b0;
        case (op)
            OP_TICK: begin
                beat = ~beat;
                if (quiet_left != 0) begin
                    quiet_left = quiet_left - 1'b1;
                    if (quiet_left != 0) begin
                        active = 1'b1;
                        // still bouncing: panic countdown runs
                        if (bounce_left != 0) begin
                            bounce_left = bounce_left - 1'b1;
                            if (bounce_left == 0)
                                loads = '0;
                        end
                    end else begin
                        bounce_left = bounce_limit;
                        loads       = pick_loads(pins);
                    end
                end
                if (awake_left != 0) begin
                    awake_left = awake_left - 1'b1;
                    if (awake_left != 0)
                        active = 1'b1;
                end
                busy = active;
            end
            OP_EDGE: quiet_left = quiet_ticks;
            OP_BYTE: awake_left = serial_load;
            OP_WAKE: begin
                awake_left = wake_load;
                busy       = 1'b1;
            end
            default: ;
        endcase
        r.drive         = loads;
        r.heartbeat_led = beat;
        r.running       = busy;
    endtask

    always @(posedge aclk) begin : watch
        dlsc_res_t want;
        dlsc_res_t got;
        if (!aresetn) begin
            quiet_ticks  = DEBOUNCE_RESET;
            bounce_limit = PANIC_RESET;
            serial_load  = KEEPALIVE_RESET;
            wake_load    = WAKEUP_RESET;
            quiet_left   = STARTUP_TICKS;
            bounce_left  = PANIC_RESET;
            awake_left   = '0;
            loads        = '0;
            beat         = 1'b0;
            busy         = 1'b1;
            status_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DEBOUNCE:  quiet_ticks  = cfg_wdata;
                    REG_PANIC:     bounce_limit = cfg_wdata;
                    REG_KEEPALIVE: serial_load  = cfg_wdata;
                    REG_WAKEUP:    wake_load    = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                step_status(s_tuser, s_tdata[2:0], want);
                status_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[6:0];
                if (status_q.size() == 0) begin
                    if (fails < 10)
                        $display("status word %0d arrived with none outstanding: %b",
                                 word_no, m_tdata);
                    fails = fails + 1;
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        if (fails < 10) begin
                            for (int i = 0; i < 7; i++) begin
                                if (got[i] !== want[i])
                                    $display("status word %0d %s: expected %b, got %b",
                                             word_no, field_name[i], want[i], got[i]);
                            end
                        end
                        fails = fails + 1;
                    end
                end
                word_no = word_no + 1;
            end
        end
        pending <= status_q.size();
    end

endmodule

FILE: tb/tb.sv
// top of the testbench: clock, reset, event stimulus, settings and verdict
module tb;
    import dlsc_pkg::*;

    typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_t;

    // pin patterns {battery_good, home_switch_n, away_switch_n}
    localparam logic [2:0] PINS_HOME    = 3'b101;
    localparam logic [2:0] PINS_AWAY    = 3'b110;
    localparam logic [2:0] PINS_BOTH    = 3'b100;
    localparam logic [2:0] PINS_BOTH_LO = 3'b000;
    localparam logic [2:0] PINS_NONE    = 3'b111;

    localparam int LIMIT      = 300000;
    localparam int PHASE_WORDS = 86;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic [OP_W-1:0]     s_tuser   = OP_TICK;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;
    logic                cfg_we    = 1'b0;
    logic [CIDX_W-1:0]   cfg_index = REG_DEBOUNCE;
    logic [CNT_W-1:0]    cfg_wdata = '0;

    int    pending;
    int    fails;
    int    cycle_count = 0;
    flow_t flow        = FLOW_FREE;
    bit    want_hold   = 1'b0;
    bit    hold_taken  = 1'b0;
    int    hold_left   = 0;

    debounced_load_switch_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    dlsc_checker u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pending   (pending),
        .fails     (fails)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic bit src_gap();
        case (flow)
            FLOW_SRC_IDLE: return $urandom_range(99) < 69;
            FLOW_BOTH:     return $urandom_range(99) < 18;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit snk_stall();
        case (flow)
            FLOW_SNK_STALL: return $urandom_range(99) < 69;
            FLOW_BOTH:      return $urandom_range(99) < 18;
            default:        return 1'b0;
        endcase
    endfunction

    // receiver side, with one long hold-off on request
    always @(posedge aclk) begin
        if (want_hold && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = 80;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  = hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= !snk_stall();
        end
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic [2:0] pins);
        while (src_gap()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, pins};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending and wait until every status word is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [CNT_W-1:0] quiet, input logic [CNT_W-1:0] panic,
                                  input logic [CNT_W-1:0] serial, input logic [CNT_W-1:0] wake);
        logic [CNT_W-1:0] vals [4];
        vals = '{quiet, panic, serial, wake};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CIDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [2:0]      pins;
        logic [OP_W-1:0] op;
        int              r;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // startup countdown still armed, reset settings
        send_word(OP_TICK, 3'b111);
        send_word(OP_TICK, 3'b000);
        send_word(OP_EDGE, PINS_HOME);
        send_word(OP_BYTE, PINS_AWAY);
        send_word(OP_WAKE, PINS_NONE);
        drain();

        // one quiet tick settles right after an edge
        write_settings(16'd1, 16'd1, 16'd3, 16'd0);
        send_word(OP_EDGE, PINS_NONE);
        send_word(OP_TICK, PINS_HOME);
        send_word(OP_EDGE, PINS_NONE);
        send_word(OP_TICK, PINS_AWAY);
        send_word(OP_EDGE, PINS_NONE);
        send_word(OP_TICK, PINS_BOTH);
        send_word(OP_EDGE, PINS_NONE);
        send_word(OP_TICK, PINS_BOTH_LO);
        send_word(OP_EDGE, PINS_NONE);
        send_word(OP_TICK, PINS_NONE);
        send_word(OP_EDGE, PINS_NONE);
        send_word(OP_TICK, PINS_AWAY);
        // keep-awake from a byte, then a wake with a zero load
        send_word(OP_BYTE, PINS_NONE);
        send_word(OP_TICK, PINS_AWAY);
        send_word(OP_TICK, PINS_AWAY);
        send_word(OP_WAKE, PINS_NONE);
        send_word(OP_TICK, PINS_AWAY);
        drain();

        // panic expires while the debounce countdown is still running
        write_settings(16'd3, 16'd1, 16'd0, 16'd2);
        send_word(OP_EDGE, PINS_HOME);
        send_word(OP_TICK, PINS_HOME);
        send_word(OP_TICK, PINS_HOME);
        send_word(OP_TICK, PINS_HOME);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_settings(16'd1, 16'd1, 16'd0, 16'd0);
                    flow = FLOW_FREE;
                end
                1: begin
                    write_settings(16'd3, 16'd5, 16'd7, 16'd2);
                    flow = FLOW_SRC_IDLE;
                end
                2: begin
                    write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    flow = FLOW_SNK_STALL;
                end
                3: begin
                    write_settings(CNT_W'($urandom_range(8, 1)), CNT_W'($urandom_range(12, 1)),
                                   CNT_W'($urandom_range(20)), CNT_W'($urandom_range(20)));
                    flow = FLOW_BOTH;
                end
                4: begin
                    write_settings(16'd4, 16'd2, 16'd1, 16'd1);
                    flow      = FLOW_FREE;
                    want_hold = 1'b1;
                end
                default: begin
                    write_settings(CNT_W'($urandom_range(6, 1)), CNT_W'($urandom_range(6, 1)),
                                   CNT_W'($urandom_range(9)), CNT_W'($urandom_range(9)));
                    flow = FLOW_SRC_IDLE;
                end
            endcase
            pins = 3'($urandom_range(7));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // switches mostly hold still, with an occasional change
                if ($urandom_range(5) == 0)
                    pins = 3'($urandom_range(7));
                r = $urandom_range(99);
                if (r < 55)
                    op = OP_TICK;
                else if (r < 75)
                    op = OP_EDGE;
                else if (r < 88)
                    op = OP_BYTE;
                else
                    op = OP_WAKE;
                send_word(op, pins);
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: debounced_load_switch_controller.f
rtl/dlsc_pkg.sv
rtl/dlsc_cfg.sv
rtl/dlsc_core.sv
rtl/debounced_load_switch_controller.sv
tb/dlsc_checker.sv
tb/tb.sv
